// ----- src/tdc_pkg.sv -----
`default_nettype none
package tdc_pkg;

  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Request kinds carried in the input tuser.
  localparam logic [REQ_W-1:0] REQ_TICK       = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET_ENABLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SET_LEVEL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MEDIUM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS = 3'd4;

  localparam logic [LEVEL_W-1:0] RST_LEVEL_LOW    = 7'd75;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_MEDIUM = 7'd96;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_HIGH   = 7'd127;
  localparam logic [COUNT_W-1:0] RST_HOLD_TICKS   = 10'd100;
  localparam logic [COUNT_W-1:0] RST_REPEAT_TICKS = 10'd20;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_low;
    logic [LEVEL_W-1:0] level_medium;
    logic [LEVEL_W-1:0] level_high;
    logic [COUNT_W-1:0] hold_ticks;
    logic [COUNT_W-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic               touch_pressed;
    logic [LEVEL_W-1:0] remote_value;
  } item_t;

  typedef struct packed {
    logic               touch_changed;
    logic [LEVEL_W-1:0] brightness_now;
    logic               enabled_now;
    logic               write_strobe;
    logic [LEVEL_W-1:0] drive_value;
  } result_t;

endpackage
`default_nettype wire

// ----- src/tdc_cfg_regs.sv -----
`default_nettype none
module tdc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [tdc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [tdc_pkg::CFG_DATA_W-1:0] wr_data,
  output tdc_pkg::cfg_t                       cfg
);

  tdc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_low    <= tdc_pkg::RST_LEVEL_LOW;
      cfg_r.level_medium <= tdc_pkg::RST_LEVEL_MEDIUM;
      cfg_r.level_high   <= tdc_pkg::RST_LEVEL_HIGH;
      cfg_r.hold_ticks   <= tdc_pkg::RST_HOLD_TICKS;
      cfg_r.repeat_ticks <= tdc_pkg::RST_REPEAT_TICKS;
    end else if (wr_en) begin
      unique case (wr_index)
        tdc_pkg::CFG_LEVEL_LOW:    cfg_r.level_low    <= wr_data[tdc_pkg::LEVEL_W-1:0];
        tdc_pkg::CFG_LEVEL_MEDIUM: cfg_r.level_medium <= wr_data[tdc_pkg::LEVEL_W-1:0];
        tdc_pkg::CFG_LEVEL_HIGH:   cfg_r.level_high   <= wr_data[tdc_pkg::LEVEL_W-1:0];
        tdc_pkg::CFG_HOLD_TICKS:   cfg_r.hold_ticks   <= wr_data[tdc_pkg::COUNT_W-1:0];
        tdc_pkg::CFG_REPEAT_TICKS: cfg_r.repeat_ticks <= wr_data[tdc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- src/tdc_step.sv -----
`default_nettype none
module tdc_step (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    fire,
  input  wire tdc_pkg::cfg_t  cfg,
  input  wire tdc_pkg::item_t item,
  output tdc_pkg::result_t result
);

  logic                          was_pressed_r, was_pressed_nxt;
  logic                          light_on_r, light_on_nxt;
  logic [tdc_pkg::LEVEL_W-1:0]   brightness_r, brightness_nxt;
  logic [tdc_pkg::COUNT_W-1:0]   hold_count_r, hold_count_nxt;
  logic [tdc_pkg::COUNT_W-1:0]   repeat_count_r, repeat_count_nxt;
  logic [tdc_pkg::LEVEL_W-1:0]   step_level;
  logic [tdc_pkg::COUNT_W-1:0]   repeat_inc;
  logic                          strobe, changed;

  // Level chosen by a fresh press.
  always_comb begin
    priority if (!light_on_r)                         step_level = cfg.level_low;
    else if (brightness_r == cfg.level_high)          step_level = '0;
    else if (brightness_r == '0)                      step_level = cfg.level_low;
    else if (cfg.level_low > brightness_r)            step_level = cfg.level_low;
    else if (cfg.level_medium > brightness_r)         step_level = cfg.level_medium;
    else if (cfg.level_high > brightness_r)           step_level = cfg.level_high;
    else                                              step_level = '0;
  end

  assign repeat_inc = (repeat_count_r == tdc_pkg::COUNT_MAX) ? repeat_count_r
                                                             : repeat_count_r + 1'b1;

  always_comb begin
    was_pressed_nxt  = was_pressed_r;
    light_on_nxt     = light_on_r;
    brightness_nxt   = brightness_r;
    hold_count_nxt   = hold_count_r;
    repeat_count_nxt = repeat_count_r;
    strobe           = 1'b0;
    changed          = 1'b0;
    unique case (item.req_type)
      tdc_pkg::REQ_TICK: begin
        if (!item.touch_pressed) begin
          was_pressed_nxt = 1'b0;
        end else if (!was_pressed_r) begin
          brightness_nxt   = step_level;
          light_on_nxt     = (step_level != '0);
          was_pressed_nxt  = 1'b1;
          hold_count_nxt   = '0;
          repeat_count_nxt = '0;
          strobe           = 1'b1;
          changed          = 1'b1;
        end else if (hold_count_r > cfg.hold_ticks) begin
          // Ramp-down phase: one step each time the repeat interval is exceeded.
          repeat_count_nxt = repeat_inc;
          if (repeat_inc > cfg.repeat_ticks && light_on_r && brightness_r != '0) begin
            brightness_nxt   = brightness_r - 1'b1;
            repeat_count_nxt = '0;
            strobe           = 1'b1;
            changed          = 1'b1;
          end
        end else begin
          if (hold_count_r != tdc_pkg::COUNT_MAX) begin
            hold_count_nxt = hold_count_r + 1'b1;
          end
          repeat_count_nxt = '0;
        end
      end
      tdc_pkg::REQ_SET_ENABLE: begin
        light_on_nxt = (item.remote_value != '0);
        strobe       = 1'b1;
      end
      tdc_pkg::REQ_SET_LEVEL: begin
        brightness_nxt = item.remote_value;
        strobe         = light_on_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r  <= 1'b0;
      light_on_r     <= 1'b0;
      brightness_r   <= '0;
      hold_count_r   <= '0;
      repeat_count_r <= '0;
    end else if (fire) begin
      was_pressed_r  <= was_pressed_nxt;
      light_on_r     <= light_on_nxt;
      brightness_r   <= brightness_nxt;
      hold_count_r   <= hold_count_nxt;
      repeat_count_r <= repeat_count_nxt;
    end
  end

  always_comb begin
    result.drive_value    = light_on_nxt ? brightness_nxt : '0;
    result.write_strobe   = strobe;
    result.enabled_now    = light_on_nxt;
    result.brightness_now = brightness_nxt;
    result.touch_changed  = changed;
  end

endmodule
`default_nettype wire

// ----- src/touch_dimmer_level_controller.sv -----
// Touch dimmer level controller.
// The input stream carries one request per item: the kind in in_tuser (sample
// tick, set enable, set brightness) and the touch state and remote value in
// in_tdata. Every accepted item yields exactly one result item on the out_
// stream with the drive value, strobe, on/off state, brightness and a touch
// change flag.
// Configuration registers (levels and hold/repeat tick counts) are written on
// the cfg_ channel, which is always ready; write them only while the block is
// idle. Indexes beyond the register list are ignored.
// An accepted item sits in the input register while the step logic works on it,
// and the result register takes it once the output register is free or being
// emptied, which raises out_tvalid. The step logic updates the light state as
// the item moves on, so one item per cycle is sustained while out_tready is high.
// If the receiver holds out_tready low, the result waits in the output
// register and one more item is taken into the input register; after that
// in_tready drops until the result is taken.
// Synchronous reset clears the light state and counters and loads the
// default levels (75, 96, 127) and tick counts (100 hold, 20 repeat).
`default_nettype none
module touch_dimmer_level_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [0] touch_pressed, [7:1] remote_value
  input  wire logic [tdc_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] req_type
  input  wire logic [tdc_pkg::REQ_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [6:0] drive_value, [7] write_strobe, [8] enabled_now,
  // [15:9] brightness_now, [16] touch_changed, [23:17] zero
  output logic [tdc_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned RES_W = $bits(tdc_pkg::result_t);

  tdc_pkg::cfg_t    cfg;
  tdc_pkg::item_t   item_r;
  tdc_pkg::result_t step_result;
  tdc_pkg::result_t result_r;
  logic             in_v_r;
  logic             out_v_r;
  logic             advance;

  assign cfg_ready = 1'b1;

  tdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The item in the input register moves on when the output register is free or its result is being taken.
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.req_type      <= in_tuser;
      item_r.touch_pressed <= in_tdata[0];
      item_r.remote_value  <= in_tdata[tdc_pkg::LEVEL_W:1];
    end
  end

  tdc_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .cfg    (cfg),
    .item   (item_r),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= step_result;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(tdc_pkg::OUT_DATA_W-RES_W){1'b0}}, result_r};

  a_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !result_r.enabled_now |-> result_r.drive_value == '0)
    else $error("drive value nonzero while light is off");

  a_drive_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && result_r.enabled_now |-> result_r.drive_value == result_r.brightness_now)
    else $error("drive value differs from brightness while light is on");

  a_change_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && result_r.touch_changed |-> result_r.write_strobe)
    else $error("light change without write strobe");

  a_move_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !out_v_r |=> out_v_r)
    else $error("pending item did not reach the output register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_v_r && out_v_r && !out_tready)
    else $error("input stalled while a stage was free");

endmodule
`default_nettype wire
